// ===== rtl/core/sqtg_pkg.sv =====
// ----------------------------------------------------------------------------
// sqtg_pkg
// Shared types and constants of the square-wave tone generator: request
// codes, field widths, divider and budget pipeline sizing, and the
// control/status structs.
// ----------------------------------------------------------------------------
package sqtg_pkg;

	// Field widths of an item
	localparam int REQ_W  = 2;
	localparam int PIN_W  = 7;
	localparam int FREQ_W = 16;
	localparam int MS_W   = 32;
	localparam int CLK_W  = 32;
	localparam int CNT_W  = 32;

	// Packed stream widths, rounded up to whole bytes
	localparam int IN_FIELDS_W  = PIN_W + FREQ_W + MS_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 + PIN_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Request codes carried in tuser
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_START = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

	// Reset value of the tick frequency register
	localparam logic [CLK_W-1:0] CLK_HZ_RESET = 32'd12000000;

	// Toggle budget that never runs out, and the ceiling of a computed budget
	localparam logic [CNT_W-1:0] TONE_FOREVER = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] TONE_MAX     = TONE_FOREVER - 1'b1;

	// Match divider: clk_hz / (2 * freq)
	localparam int DIV_W     = CLK_W;
	localparam int DIVR_W    = FREQ_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

	// Toggle budget 2 * freq * ms / 1000, formed as freq * ms / 500. A division
	// by 500 is a shift by two followed by a reciprocal multiply for 125, which
	// is exact for any dividend below 2^30.
	localparam int                 RECIP_W   = 31;
	localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;
	localparam int                 RECIP_SH  = 37;
	localparam int                 DUR_Q_W   = 24;   // ms / 500
	localparam int                 DUR_R_W   = 9;    // ms % 500
	localparam logic [MS_W-1:0]    DUR_DIV   = 32'd500;
	localparam int                 FA_W      = FREQ_W + DUR_Q_W;
	localparam int                 FB_W      = FREQ_W + DUR_R_W;
	localparam int                 MS_PROD_W = MS_W - 2 + RECIP_W;
	localparam int                 FB_PROD_W = FB_W - 2 + RECIP_W;
	localparam int                 TOG_W     = FA_W + 1;

	typedef struct packed {
		logic step;       // apply a tick, stop or ignored request at once
		logic capture;    // hold the fields of a start request
		logic div_start;  // launch the match divider
		logic half_save;  // keep the clock quotient
		logic commit;     // load the new tone and its result
	} sqtg_cmd_t;

	typedef struct packed {
		logic freq_nz;    // frequency field of the offered item is nonzero
		logic div_done;   // divider finishes its last step this cycle
	} sqtg_status_t;

endpackage

// ===== rtl/core/sqtg_div.sv =====
// ----------------------------------------------------------------------------
// sqtg_div
// Restoring divider, one quotient bit per cycle, used for the match value
// computation.
// ----------------------------------------------------------------------------
module sqtg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sqtg_pkg::DIV_W-1:0]  dividend,
	input  logic [sqtg_pkg::DIVR_W-1:0] divisor,
	output logic                      done,
	output logic [sqtg_pkg::DIV_W-1:0]  quotient
);
	import sqtg_pkg::*;

	logic [DIV_W-1:0]     dq_q;
	logic [DIVR_W-1:0]    rem_q;
	logic [DIVR_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DIVR_W:0]      trial;
	logic [DIVR_W:0]      diff;

	// The partial remainder stays below the divisor, so bit DIVR_W of the
	// difference is a clean borrow flag.
	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_LAST;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[DIVR_W]) begin
				rem_q <= diff[DIVR_W-1:0];
				dq_q  <= {dq_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIVR_W-1:0];
				dq_q  <= {dq_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = dq_q;

endmodule

// ===== rtl/core/sqtg_dp.sv =====
// ----------------------------------------------------------------------------
// sqtg_dp
// Datapath: tone state, tick frequency register, match divider, toggle
// budget pipeline and the result register.
// ----------------------------------------------------------------------------
module sqtg_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sqtg_pkg::CLK_W-1:0]     cfg_wdata,
	input  logic [sqtg_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [sqtg_pkg::REQ_W-1:0]     s_tuser,
	input  sqtg_pkg::sqtg_cmd_t            cmd,
	output sqtg_pkg::sqtg_status_t         status,
	output logic [sqtg_pkg::OUT_DATA_W-1:0] m_tdata
);
	import sqtg_pkg::*;

	// Fields of the offered item
	logic [PIN_W-1:0]  in_pin;
	logic [FREQ_W-1:0] in_freq;
	logic [MS_W-1:0]   in_ms;

	assign in_pin  = s_tdata[PIN_W-1:0];
	assign in_freq = s_tdata[PIN_W+FREQ_W-1:PIN_W];
	assign in_ms   = s_tdata[IN_FIELDS_W-1:PIN_W+FREQ_W];

	// Tone state
	logic [CLK_W-1:0] clk_hz_q;
	logic [CNT_W-1:0] tick_q;
	logic [CNT_W-1:0] match_q;
	logic [CNT_W-1:0] toggles_q;
	logic             level_q;
	logic             running_q;
	logic             assigned_q;
	logic [PIN_W-1:0] pin_q;

	// Start request working registers
	logic [PIN_W-1:0]  new_pin_q;
	logic [FREQ_W-1:0] freq_q;
	logic [MS_W-1:0]   ms_q;
	logic [CNT_W-1:0]  half_q;
	logic [OUT_FIELDS_W-1:0] out_q;

	// Divider hookup
	logic [DIV_W-1:0]  div_dividend;
	logic [DIVR_W-1:0] div_divisor;
	logic [DIV_W-1:0]  div_quot;
	logic              div_done;

	assign div_dividend = clk_hz_q;
	assign div_divisor  = {freq_q, 1'b0};

	sqtg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign status.freq_nz  = (in_freq != '0);
	assign status.div_done = div_done;

	// Toggle budget pipeline. With ms = 500 * q + r the budget is
	// freq * q + (freq * r) / 500. It runs freely from the captured fields,
	// through registers s1 to s4, and settles well inside the divider's run.
	logic [MS_PROD_W-1:0] ms_prod;
	logic [MS_W-1:0]      ms_rem;
	logic [FB_PROD_W-1:0] fb_prod;
	logic [DUR_Q_W-1:0]   durq_s1;
	logic [DUR_R_W-1:0]   durr_s2;
	logic [FA_W-1:0]      fa_s2;
	logic [FA_W-1:0]      fa_s3;
	logic [FB_W-1:0]      fb_s3;
	logic [FA_W-1:0]      fa_s4;
	logic [FREQ_W-1:0]    fbq_s4;

	assign ms_prod = MS_PROD_W'(ms_q[MS_W-1:2]) * MS_PROD_W'(RECIP_125);
	assign ms_rem  = ms_q - MS_W'(durq_s1) * DUR_DIV;
	assign fb_prod = FB_PROD_W'(fb_s3[FB_W-1:2]) * FB_PROD_W'(RECIP_125);

	always_ff @(posedge clk) begin
		durq_s1 <= ms_prod[RECIP_SH+DUR_Q_W-1:RECIP_SH];
		durr_s2 <= ms_rem[DUR_R_W-1:0];
		fa_s2   <= FA_W'(freq_q) * FA_W'(durq_s1);
		fb_s3   <= FB_W'(freq_q) * FB_W'(durr_s2);
		fa_s3   <= fa_s2;
		fbq_s4  <= fb_prod[RECIP_SH+FREQ_W-1:RECIP_SH];
		fa_s4   <= fa_s3;
	end

	// Next state for a tick or stop applied at once
	logic [CNT_W-1:0] tick_nxt;
	logic [CNT_W-1:0] toggles_nxt;
	logic             level_nxt;
	logic             running_nxt;

	always_comb begin
		tick_nxt    = tick_q;
		toggles_nxt = toggles_q;
		level_nxt   = level_q;
		running_nxt = running_q;
		case (s_tuser)
			REQ_TICK: begin
				if (running_q && assigned_q) begin
					if (tick_q < match_q) begin
						tick_nxt = tick_q + 1'b1;
					end else begin
						tick_nxt = '0;
						if (toggles_q == '0) begin
							running_nxt = 1'b0;
							level_nxt   = 1'b0;
						end else begin
							if (toggles_q != TONE_FOREVER) begin
								toggles_nxt = toggles_q - 1'b1;
							end
							level_nxt = ~level_q;
						end
					end
				end
			end
			REQ_STOP: begin
				if (assigned_q && (in_pin == pin_q)) begin
					running_nxt = 1'b0;
					level_nxt   = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// Match value and toggle budget of a finished start
	logic [CNT_W-1:0] match_new;
	logic [CNT_W-1:0] toggles_new;
	logic [TOG_W-1:0] tog_sum;
	logic             tog_sat;

	assign match_new = (half_q == '0) ? '0 : half_q - 1'b1;
	assign tog_sum   = TOG_W'(fa_s4) + TOG_W'(fbq_s4);
	assign tog_sat   = (tog_sum >= TOG_W'(TONE_FOREVER));

	always_comb begin
		if (ms_q == '0) begin
			toggles_new = TONE_FOREVER;
		end else if (tog_sat) begin
			toggles_new = TONE_MAX;
		end else begin
			toggles_new = tog_sum[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q   <= CLK_HZ_RESET;
			tick_q     <= '0;
			match_q    <= '0;
			toggles_q  <= '0;
			level_q    <= 1'b0;
			running_q  <= 1'b0;
			assigned_q <= 1'b0;
			pin_q      <= '0;
		end else begin
			if (cfg_we) begin
				clk_hz_q <= cfg_wdata;
			end
			if (cmd.step) begin
				tick_q    <= tick_nxt;
				toggles_q <= toggles_nxt;
				level_q   <= level_nxt;
				running_q <= running_nxt;
			end else if (cmd.commit) begin
				tick_q     <= '0;
				match_q    <= match_new;
				toggles_q  <= toggles_new;
				level_q    <= 1'b0;
				running_q  <= 1'b1;
				assigned_q <= 1'b1;
				pin_q      <= new_pin_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			new_pin_q <= in_pin;
			freq_q    <= in_freq;
			ms_q      <= in_ms;
		end
		if (cmd.half_save) begin
			half_q <= div_quot[CNT_W-1:0];
		end
		if (cmd.step) begin
			out_q <= {pin_q, running_nxt, level_nxt};
		end else if (cmd.commit) begin
			out_q <= {new_pin_q, 1'b1, 1'b0};
		end
	end

	assign m_tdata = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, out_q};

endmodule

// ===== rtl/core/sqtg_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqtg_ctrl
// Controller: handshakes, result valid flag and the sequence that turns a
// start request into a match value and toggle budget.
// ----------------------------------------------------------------------------
module sqtg_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic [sqtg_pkg::REQ_W-1:0] s_tuser,
	output logic                      s_tready,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	input  sqtg_pkg::sqtg_status_t     status,
	output sqtg_pkg::sqtg_cmd_t        cmd
);
	import sqtg_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_LAUNCH  = 3'd1;
	localparam logic [2:0] ST_DIV_CLK = 3'd2;
	localparam logic [2:0] ST_SAVE    = 3'd3;
	localparam logic [2:0] ST_FIN     = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       m_valid_q;
	logic       slot_free;
	logic       accept;
	logic       load_out;

	assign slot_free = !m_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((s_tuser == REQ_START) && status.freq_nz) begin
						cmd.capture = 1'b1;
						state_nxt   = ST_LAUNCH;
					end else begin
						cmd.step = 1'b1;
						load_out = 1'b1;
					end
				end
			end
			ST_LAUNCH: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_DIV_CLK;
			end
			ST_DIV_CLK: begin
				if (status.div_done) begin
					state_nxt = ST_SAVE;
				end
			end
			ST_SAVE: begin
				cmd.half_save = 1'b1;
				state_nxt     = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					load_out   = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/square_wave_tone_generator.sv =====
// ----------------------------------------------------------------------------
// square_wave_tone_generator
// Timer-match square-wave tone generator driven by a stream of tick, start
// and stop items, one status item returned for each.
// ----------------------------------------------------------------------------
// Usage:
// Each input item carries a request kind in s_tuser (tick, start, stop) and
// the pin, frequency and duration in s_tdata. Every accepted item yields
// exactly one result item on the master side, giving the pin level, whether
// the tone runs, and the assigned pin, as they stand after the request.
// Ticks, stops and ignored requests return their result in the cycle after
// acceptance, and a new item may be accepted every cycle while the receiver
// takes each result, so a tick stream can run at full clock rate.
// A start with a nonzero frequency passes a launch state, 32 steps of the
// one-bit-per-cycle divider for the match value, a state to keep the
// quotient and a commit state that waits for a free result slot. The
// toggle budget comes from a short multiplier pipeline that finishes while
// the divider runs. No input item is accepted meanwhile.
// The user writes the tick frequency register through cfg_we / cfg_wdata
// only while the block is idle (not enforced); reset loads it with 12 MHz.
// Reset clears all tone state: no pin assigned, output low, timer stopped.
// When the receiver stalls, the result register holds its item and the
// input side stops accepting until that item has been taken.
// ----------------------------------------------------------------------------
module square_wave_tone_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	// Tick frequency register
	input  logic                           cfg_we,
	input  logic [sqtg_pkg::CLK_W-1:0]      cfg_wdata,
	// Request stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// From bit 0: pin_index[6:0], tone_freq_hz[22:7], duration_ms[54:23], zero
	input  logic [sqtg_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type[1:0]
	input  logic [sqtg_pkg::REQ_W-1:0]      s_tuser,
	// Status stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// From bit 0: pin_level[0], tone_running[1], active_pin[8:2], zero
	output logic [sqtg_pkg::OUT_DATA_W-1:0] m_tdata
);
	import sqtg_pkg::*;

	sqtg_cmd_t    cmd;
	sqtg_status_t status;

	// The controller sequences start requests and owns both handshakes.
	sqtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the tone state, arithmetic and the result register.
	sqtg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.status    (status),
		.m_tdata   (m_tdata)
	);

endmodule
